// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: operation and
// status codes, field widths and the per-item control word sent to the cells.
// ----------------------------------------------------------------------------
package ils_pkg;

	// default sizing of the store
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the item channels
	localparam int OP_W  = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;
	localparam int LEN_W = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_READ   = 3'd2,
		OP_WRITE  = 3'd3,
		OP_REMOVE = 3'd4,
		OP_POP    = 3'd5,
		OP_CLEAR  = 3'd6
	} op_t;

	// status codes
	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// control word broadcast to every cell, already qualified by the checks
	typedef struct packed {
		logic do_append;
		logic do_insert;
		logic do_write;
		logic do_remove;
		logic do_read;
		logic do_pop;
	} cell_ctl_t;

endpackage

// ===== rtl/ils_if.sv =====
// ----------------------------------------------------------------------------
// ils_if
// Valid/ready channels of the indexed list store: the request channel and
// the response channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ils_req_if;
	logic                       valid;
	logic                       ready;
	logic [ils_pkg::OP_W-1:0]   operation;
	logic [ils_pkg::POS_W-1:0]  position;
	logic signed [ils_pkg::VAL_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface ils_rsp_if;
	logic                       valid;
	logic                       ready;
	logic signed [ils_pkg::VAL_W-1:0] read_value;
	logic [ils_pkg::STS_W-1:0]  status;
	logic [ils_pkg::LEN_W-1:0]  length;
	logic                       is_empty;

	modport source (output valid, output read_value, output status, output length,
		output is_empty, input ready);
	modport sink (input valid, input read_value, input status, input length,
		input is_empty, output ready);
endinterface

// ===== rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One storage cell of the list. It holds the element at its own index and,
// on insert or remove, takes the element of its left or right neighbour.
// ----------------------------------------------------------------------------
module ils_cell #(
	parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF,
	parameter int CMP_W      = 7,
	parameter int INDEX      = 0
) (
	input  logic                    clk,
	input  ils_pkg::cell_ctl_t      ctl,
	input  logic [CMP_W-1:0]        pos,
	input  logic [CMP_W-1:0]        count,
	input  logic [DATA_WIDTH-1:0]   wr_data,
	input  logic [DATA_WIDTH-1:0]   left_data,
	input  logic [DATA_WIDTH-1:0]   right_data,
	output logic [DATA_WIDTH-1:0]   data,
	output logic [DATA_WIDTH-1:0]   rd_data
);
	import ils_pkg::*;

	localparam logic [CMP_W-1:0] IDX      = CMP_W'(INDEX);
	localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(INDEX + 1);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  at_pos;

	assign at_pos = (IDX == pos);

	// next element held by this cell
	always_comb begin
		data_d = data_q;
		if (ctl.do_append && IDX == count) begin
			data_d = wr_data;
		end
		if (ctl.do_write && at_pos) begin
			data_d = wr_data;
		end
		if (ctl.do_insert) begin
			if (at_pos) begin
				data_d = wr_data;
			end else if (IDX > pos && IDX <= count) begin
				data_d = left_data;
			end
		end
		if (ctl.do_remove && IDX >= pos && IDX_NEXT < count) begin
			data_d = right_data;
		end
	end

	// element register
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

	// gated read towards the collecting or-tree
	assign rd_data = ((ctl.do_read && at_pos) || (ctl.do_pop && IDX_NEXT == count))
		? data_q : '0;

endmodule

// ===== rtl/indexed_list_store_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Packed ordered list with append, insert, read, write, remove, pop and clear.
// ----------------------------------------------------------------------------
// Each request item is taken on its handshake and its response item appears in the
// response register on the next cycle; a new request is accepted in every
// cycle as long as the response register is empty or being drained, so the
// sustained rate is one item per clock. That figure comes from the row of
// DEPTH cells: every cell holds one element and on insert or remove all of
// them load from their neighbour at once, so no operation iterates over the
// list. Reads and pops collect the chosen cell through an or-tree. Stored
// elements are not cleared by reset or by clear; only the element count is.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
	parameter int DEPTH      = ils_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ils_req_if.sink      req,
	ils_rsp_if.source    rsp
);
	import ils_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic                   rsp_valid_q;
	logic signed [VAL_W-1:0] read_value_q;
	logic [STS_W-1:0]       status_q;
	logic [LEN_W-1:0]       length_q;
	logic                   is_empty_q;

	logic                   accept;
	logic [CMP_W-1:0]       pos_w;
	logic [CMP_W-1:0]       cnt_w;
	status_t                status_d;
	cell_ctl_t              ctl;
	logic [DATA_WIDTH-1:0]  wr_data;
	logic [DATA_WIDTH-1:0]  rd_any;
	logic [VAL_W-1:0]       rd_out;
	logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
	logic [DATA_WIDTH-1:0]  cell_rd [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_w = CMP_W'(req.position);
	assign cnt_w = CMP_W'(count_q);

	// fit the item value to the stored width and back
	if (DATA_WIDTH >= VAL_W) begin : g_wide
		assign wr_data = DATA_WIDTH'(unsigned'(req.value));
		assign rd_out  = rd_any[VAL_W-1:0];
	end else begin : g_narrow
		assign wr_data = req.value[DATA_WIDTH-1:0];
		assign rd_out  = VAL_W'(rd_any);
	end

	// operation decode, range checks and next count
	always_comb begin
		ctl      = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (op_t'(req.operation))
			OP_APPEND: begin
				if (cnt_w == FULL_CNT) begin
					status_d = ST_FULL;
				end else begin
					ctl.do_append = accept;
					count_d       = count_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_w > cnt_w) begin
					status_d = ST_RANGE;
				end else if (cnt_w == FULL_CNT) begin
					status_d = ST_FULL;
				end else begin
					ctl.do_insert = accept;
					count_d       = count_q + 1'b1;
				end
			end
			OP_READ: begin
				if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					ctl.do_read = 1'b1;
				end
			end
			OP_WRITE: begin
				if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					ctl.do_write = accept;
				end
			end
			OP_REMOVE: begin
				if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					ctl.do_remove = accept;
					count_d       = count_q - 1'b1;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					ctl.do_pop = 1'b1;
					count_d    = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// row of cells, each linked to its neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_right
			assign right_data = cell_data[i+1];
		end

		ils_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CMP_W      (CMP_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pos        (pos_w),
			.count      (cnt_w),
			.wr_data    (wr_data),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// collect the selected cell; at most one cell drives a non-zero value
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	// element count and response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= signed'(rd_out);
			status_q     <= status_d;
			length_q     <= LEN_W'(count_d);
			is_empty_q   <= (count_d == '0);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;
	assign rsp.is_empty   = is_empty_q;

endmodule

// ===== tb/tb_indexed_list_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// Self-checking bench for the indexed list store. A short table of hand-made
// requests covers the edge cases, then random requests are driven in runs
// that fill the list, drain it and churn it. Every response is compared with
// a typed-in value or a shadow copy of the list kept in the bench. The source
// idles and the sink stalls in several phases of the run.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;

	import ils_pkg::*;

	localparam int          LIST_DEPTH     = DEPTH_DEF;
	localparam int          ITEMS_PER_PASS = 375;
	localparam int          STALL_LIMIT    = 2000;
	localparam int          SCRIPT_LEN     = 24;
	localparam logic [2:0]  OP_UNUSED      = 3'd7;

	// direction the random stream pushes the fill level
	localparam int TREND_GROW   = 0;
	localparam int TREND_SHRINK = 1;
	localparam int TREND_CHURN  = 2;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		status_t                 status;
		logic [LEN_W-1:0]        length;
		logic                    is_empty;
	} resp_t;

	typedef struct packed {
		req_item_t item;
		logic      typed;
		resp_t     want;
	} script_row_t;

	logic clk;
	logic arst_n;

	ils_req_if req_ch ();
	ils_rsp_if rsp_ch ();

	indexed_list_store_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the list
	logic signed [VAL_W-1:0] mirror_elems [0:LIST_DEPTH-1];
	int                      mirror_count;

	resp_t       pending_responses [$];
	script_row_t script_rows [0:SCRIPT_LEN-1];
	int          mismatches;
	int          src_idle_pct;
	int          snk_stall_pct;
	int          quiet_cycles;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// known values on every input from time zero
	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = '0;
		req_ch.position  = '0;
		req_ch.value     = '0;
		rsp_ch.ready     = 1'b0;
		src_idle_pct     = 0;
		snk_stall_pct    = 0;
		mirror_count     = 0;
		mismatches       = 0;
		quiet_cycles     = 0;
	end

	// shadow list update, returns the response the block should give
	function automatic resp_t apply_list_op(input req_item_t it);
		resp_t r;
		int    pos;
		int    k;
		pos          = int'(it.position);
		r.read_value = '0;
		r.status     = ST_OK;
		case (it.operation)
			OP_APPEND: begin
				if (mirror_count >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					mirror_elems[mirror_count] = it.value;
					mirror_count++;
				end
			end
			OP_INSERT: begin
				if (pos > mirror_count) begin
					r.status = ST_RANGE;
				end else if (mirror_count >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = mirror_count; k > pos; k--)
						mirror_elems[k] = mirror_elems[k-1];
					mirror_elems[pos] = it.value;
					mirror_count++;
				end
			end
			OP_READ: begin
				if (pos >= mirror_count)
					r.status = ST_RANGE;
				else
					r.read_value = mirror_elems[pos];
			end
			OP_WRITE: begin
				if (pos >= mirror_count)
					r.status = ST_RANGE;
				else
					mirror_elems[pos] = it.value;
			end
			OP_REMOVE: begin
				if (pos >= mirror_count) begin
					r.status = ST_RANGE;
				end else begin
					for (k = pos; k + 1 < mirror_count; k++)
						mirror_elems[k] = mirror_elems[k+1];
					mirror_count--;
				end
			end
			OP_POP: begin
				if (mirror_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					mirror_count--;
					r.read_value = mirror_elems[mirror_count];
				end
			end
			OP_CLEAR: begin
				mirror_count = 0;
			end
			default: begin
			end
		endcase
		r.length   = LEN_W'(mirror_count);
		r.is_empty = (mirror_count == 0);
		return r;
	endfunction

	// drive one item, wait for it to be taken, then note its response
	task automatic send_item(input req_item_t it, input logic typed, input resp_t want);
		resp_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= it.operation;
		req_ch.position  <= it.position;
		req_ch.value     <= it.value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_list_op(it);
		if (typed)
			predicted = want;
		pending_responses = {pending_responses, predicted};
	endtask

	// element value, edge values now and then
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(0, 39))
			0:       v = 32'h7FFF_FFFF;
			1:       v = 32'h8000_0000;
			2:       v = 32'h0000_0000;
			3:       v = 32'hFFFF_FFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// index of a live element most of the time
	function automatic logic [POS_W-1:0] pick_position(input logic for_insert);
		int top;
		top = for_insert ? mirror_count : mirror_count - 1;
		if (top > LIST_DEPTH - 1)
			top = LIST_DEPTH - 1;
		if (top >= 0 && $urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, top));
		return POS_W'($urandom_range(0, LIST_DEPTH - 1));
	endfunction

	// random request shaped by the current trend
	function automatic req_item_t pick_item(input int trend);
		req_item_t it;
		int        roll;
		roll = $urandom_range(0, 99);
		case (trend)
			TREND_GROW: begin
				if (roll < 45)      it.operation = OP_APPEND;
				else if (roll < 70) it.operation = OP_INSERT;
				else if (roll < 82) it.operation = OP_READ;
				else if (roll < 92) it.operation = OP_WRITE;
				else if (roll < 95) it.operation = OP_REMOVE;
				else if (roll < 98) it.operation = OP_POP;
				else                it.operation = OP_UNUSED;
			end
			TREND_SHRINK: begin
				if (roll < 35)      it.operation = OP_REMOVE;
				else if (roll < 60) it.operation = OP_POP;
				else if (roll < 75) it.operation = OP_READ;
				else if (roll < 85) it.operation = OP_WRITE;
				else if (roll < 92) it.operation = OP_APPEND;
				else if (roll < 97) it.operation = OP_INSERT;
				else if (roll < 98) it.operation = OP_UNUSED;
				else                it.operation = OP_CLEAR;
			end
			default: begin
				it.operation = OP_W'($urandom_range(0, 7));
				if (it.operation == OP_CLEAR && $urandom_range(0, 3) != 0)
					it.operation = OP_READ;
			end
		endcase
		it.position = pick_position(it.operation == OP_INSERT);
		it.value    = pick_value();
		return it;
	endfunction

	// sink side back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// response checker
	always @(posedge clk) begin : rsp_check
		resp_t want;
		resp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.read_value = rsp_ch.read_value;
			got.status     = status_t'(rsp_ch.status);
			got.length     = rsp_ch.length;
			got.is_empty   = rsp_ch.is_empty;
			if (pending_responses.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected response item: rd=%0d st=%0d len=%0d empty=%0b",
						got.read_value, got.status, got.length, got.is_empty);
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("mismatch: want rd=%0d st=%0d len=%0d empty=%0b, got rd=%0d st=%0d len=%0d empty=%0b",
							want.read_value, want.status, want.length, want.is_empty,
							got.read_value, got.status, got.length, got.is_empty);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		int        pass;
		int        n;
		int        trend;
		int        idle_tab [0:3];
		int        stall_tab [0:3];
		req_item_t it;

		idle_tab  = '{0, 45, 0, 15};
		stall_tab = '{0, 0, 45, 15};

		// edge cases, expected values typed in where they are obvious
		script_rows[0]  = '{'{OP_POP,    6'd0,  32'sd0},        1'b1, '{32'sd0, ST_EMPTY, 7'd0, 1'b1}};
		script_rows[1]  = '{'{OP_READ,   6'd0,  32'sd0},        1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1}};
		script_rows[2]  = '{'{OP_WRITE,  6'd0,  32'sd5},        1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1}};
		script_rows[3]  = '{'{OP_REMOVE, 6'd0,  32'sd0},        1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1}};
		script_rows[4]  = '{'{OP_INSERT, 6'd1,  32'sd9},        1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1}};
		script_rows[5]  = '{'{OP_INSERT, 6'd0,  32'h7FFF_FFFF}, 1'b1, '{32'sd0, ST_OK,    7'd1, 1'b0}};
		script_rows[6]  = '{'{OP_APPEND, 6'd0,  32'h8000_0000}, 1'b1, '{32'sd0, ST_OK,    7'd2, 1'b0}};
		script_rows[7]  = '{'{OP_APPEND, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{32'sd0, ST_OK,    7'd3, 1'b0}};
		script_rows[8]  = '{'{OP_INSERT, 6'd2,  32'h0000_0000}, 1'b1, '{32'sd0, ST_OK,    7'd4, 1'b0}};
		script_rows[9]  = '{'{OP_READ,   6'd0,  32'sd0},        1'b1,
			'{32'h7FFF_FFFF, ST_OK, 7'd4, 1'b0}};
		script_rows[10] = '{'{OP_READ,   6'd1,  32'sd0},        1'b1,
			'{32'h8000_0000, ST_OK, 7'd4, 1'b0}};
		script_rows[11] = '{'{OP_READ,   6'd3,  32'sd0},        1'b1,
			'{32'hFFFF_FFFF, ST_OK, 7'd4, 1'b0}};
		script_rows[12] = '{'{OP_READ,   6'd2,  32'sd0},        1'b0, '0};
		script_rows[13] = '{'{OP_WRITE,  6'd2,  32'h5A5A_5A5A}, 1'b0, '0};
		script_rows[14] = '{'{OP_READ,   6'd2,  32'sd0},        1'b0, '0};
		script_rows[15] = '{'{OP_REMOVE, 6'd0,  32'sd0},        1'b0, '0};
		script_rows[16] = '{'{OP_READ,   6'd63, 32'sd0},        1'b1, '{32'sd0, ST_RANGE, 7'd3, 1'b0}};
		script_rows[17] = '{'{OP_INSERT, 6'd63, 32'sd1},        1'b1, '{32'sd0, ST_RANGE, 7'd3, 1'b0}};
		script_rows[18] = '{'{OP_UNUSED, 6'd63, 32'hFFFF_FFFF}, 1'b0, '0};
		script_rows[19] = '{'{OP_POP,    6'd0,  32'sd0},        1'b0, '0};
		script_rows[20] = '{'{OP_REMOVE, 6'd2,  32'sd0},        1'b1, '{32'sd0, ST_RANGE, 7'd2, 1'b0}};
		script_rows[21] = '{'{OP_CLEAR,  6'd0,  32'sd0},        1'b1, '{32'sd0, ST_OK,    7'd0, 1'b1}};
		script_rows[22] = '{'{OP_POP,    6'd0,  32'sd0},        1'b1, '{32'sd0, ST_EMPTY, 7'd0, 1'b1}};
		script_rows[23] = '{'{OP_APPEND, 6'd0,  32'h1234_5678}, 1'b0, '0};

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < SCRIPT_LEN; n++)
			send_item(script_rows[n].item, script_rows[n].typed, script_rows[n].want);

		// random runs that fill to full, drain to empty and churn
		trend = TREND_GROW;
		for (pass = 0; pass < 4; pass++) begin
			src_idle_pct  = idle_tab[pass];
			snk_stall_pct = stall_tab[pass];
			for (n = 0; n < ITEMS_PER_PASS; n++) begin
				if (trend == TREND_GROW && mirror_count >= LIST_DEPTH
						&& $urandom_range(0, 3) == 0)
					trend = TREND_SHRINK;
				else if (trend == TREND_SHRINK && mirror_count == 0
						&& $urandom_range(0, 3) == 0)
					trend = ($urandom_range(0, 2) == 0) ? TREND_CHURN : TREND_GROW;
				else if (trend == TREND_CHURN && $urandom_range(0, 29) == 0)
					trend = TREND_GROW;
				it = pick_item(trend);
				send_item(it, 1'b0, '0);
			end
		end
		req_ch.valid <= 1'b0;

		// drain outstanding responses
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
